// ----- sv/nnrs_pkg.sv -----
// ----------------------------------------------------------------------------
// nnrs_pkg
// Shared types, field widths and register codes of the row scaler.
// ----------------------------------------------------------------------------
package nnrs_pkg;

    // Defaults for the top level parameters
    localparam int DEF_MAX_DIM      = 4096;
    localparam int DEF_MAX_REPLICAS = 64;

    // Stream field widths
    localparam int COORD_W  = 12;
    localparam int PIXEL_W  = 32;
    localparam int TDATA_W  = 56;   // two coordinates and one pixel, byte aligned

    // Configuration port
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int DIMREG_W = 13;
    localparam int BPPREG_W = 3;

    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] REG_BPP        = 3'd4;

    localparam logic [DIMREG_W-1:0] DIM_RESET = 13'd1;
    localparam logic [BPPREG_W-1:0] BPP_RESET = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SETUP,
        ST_EMIT_RD,
        ST_EMIT_CHK,
        ST_EMIT,
        ST_MARK
    } state_t;

    // Span bound being divided out
    typedef enum logic [1:0] {
        JOB_Y0,
        JOB_Y1,
        JOB_X0,
        JOB_X1
    } job_t;

endpackage

// ----- sv/nearest_neighbor_row_scaler.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_row_scaler
// Nearest-neighbor upscaler/downscaler working on a stream of source pixels.
// Each pixel is replicated over its destination span, skipping rows already
// finished by an earlier source row.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    row, col, pixel; tlast row end
//  m_        out        m_tvalid / m_tready    dst x, y, pixel; tlast, overflow
//  apb       in         psel / penable         five config registers
//
//  One shared divider resolves each span bound; a new row costs up to four
//  divisions, a pixel next to the previous one costs one. The done-row scan
//  reads each row of the span when the row changes; emission reads each
//  visited row, then makes its writes; row end marking writes each row of
//  the span as done. A clearing pass runs after reset and after each
//  new-scan request; s_tready stays low meanwhile. A stalled write holds in
//  the output register while the next request is taken.
// ----------------------------------------------------------------------------
module nearest_neighbor_row_scaler #(
    parameter int MAX_DIM      = nnrs_pkg::DEF_MAX_DIM,
    parameter int MAX_REPLICAS = nnrs_pkg::DEF_MAX_REPLICAS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [nnrs_pkg::TDATA_W-1:0] s_tdata,   // src_row, src_col, pixel_in
    input  logic                         s_tuser,   // mode
    input  logic                         s_tlast,   // row_end
    // output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [nnrs_pkg::TDATA_W-1:0] m_tdata,   // dst_x, dst_y, pixel_out
    output logic                         m_tuser,   // overflow
    output logic                         m_tlast,   // last
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nnrs_pkg::APB_AW-1:0]  paddr,
    input  logic [nnrs_pkg::APB_DW-1:0]  pwdata,
    output logic [nnrs_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import nnrs_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int AW    = $clog2(MAX_DIM);
    localparam int IDX_W = COORD_W + 1;
    localparam int NUM_W = IDX_W + DIM_W;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam int CNT_W = $clog2(MAX_REPLICAS + 2);
    localparam int N_W   = $clog2(MAX_REPLICAS + 1);
    localparam int CAP   = MAX_REPLICAS + 1;
    localparam int TOT_W = CNT_W + DIM_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIMREG_W-1:0] sw_cfg_reg, sh_cfg_reg, dw_cfg_reg, dh_cfg_reg;
    logic [BPPREG_W-1:0] bpp_cfg_reg;
    logic                cfg_we;
    logic [2:0]          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_cfg_reg  <= DIM_RESET;
            sh_cfg_reg  <= DIM_RESET;
            dw_cfg_reg  <= DIM_RESET;
            dh_cfg_reg  <= DIM_RESET;
            bpp_cfg_reg <= BPP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_SRC_WIDTH:  sw_cfg_reg  <= pwdata[DIMREG_W-1:0];
                REG_SRC_HEIGHT: sh_cfg_reg  <= pwdata[DIMREG_W-1:0];
                REG_DST_WIDTH:  dw_cfg_reg  <= pwdata[DIMREG_W-1:0];
                REG_DST_HEIGHT: dh_cfg_reg  <= pwdata[DIMREG_W-1:0];
                REG_BPP:        bpp_cfg_reg <= pwdata[BPPREG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  prdata = APB_DW'(sw_cfg_reg);
            REG_SRC_HEIGHT: prdata = APB_DW'(sh_cfg_reg);
            REG_DST_WIDTH:  prdata = APB_DW'(dw_cfg_reg);
            REG_DST_HEIGHT: prdata = APB_DW'(dh_cfg_reg);
            REG_BPP:        prdata = APB_DW'(bpp_cfg_reg);
            default:        prdata = '0;
        endcase
    end

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIMREG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    logic [DIM_W-1:0] src_w, src_h, dst_w, dst_h;
    assign src_w = clamp_dim(sw_cfg_reg);
    assign src_h = clamp_dim(sh_cfg_reg);
    assign dst_w = clamp_dim(dw_cfg_reg);
    assign dst_h = clamp_dim(dh_cfg_reg);

    logic [PIXEL_W-1:0] pix_mask;
    always_comb begin
        priority case (bpp_cfg_reg)
            3'd0, 3'd1: pix_mask = 32'h0000_00FF;
            3'd2:       pix_mask = 32'h0000_FFFF;
            3'd3:       pix_mask = 32'h00FF_FFFF;
            default:    pix_mask = 32'hFFFF_FFFF;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    job_t                job_reg, job_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [COORD_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic [PIXEL_W-1:0]  pix_reg, pix_next;
    logic                end_reg, end_next;
    logic                row_miss_reg, row_miss_next;
    logic                col_hit_reg, col_hit_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [DIM_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DIM_W-1:0]    y0_reg, y0_next, y1_reg, y1_next;
    logic [DIM_W-1:0]    x0_reg, x0_next, x1_reg, x1_next;
    logic [COORD_W-1:0]  rc_row_reg, rc_row_next;
    logic                rc_valid_reg, rc_valid_next;
    logic                cc_valid_reg, cc_valid_next;
    logic [IDX_W-1:0]    cc_col_reg, cc_col_next;
    logic [CNT_W-1:0]    pend_reg, pend_next;
    logic [CNT_W-1:0]    rows_reg, rows_next;
    logic [DIM_W-1:0]    y_reg, y_next, x_reg, x_next;
    logic [N_W-1:0]      n_reg, n_next;
    logic                ovf_reg, ovf_next;
    logic                m_valid_reg, m_valid_next;
    logic [COORD_W-1:0]  m_x_reg, m_x_next, m_y_reg, m_y_next;
    logic [PIXEL_W-1:0]  m_pix_reg, m_pix_next;
    logic                m_last_reg, m_last_next, m_ovf_reg, m_ovf_next;

    // done-row map
    logic                row_done_mem [MAX_DIM];
    logic                rd_data_reg;
    logic [AW-1:0]       mem_addr;
    logic                mem_we, mem_wdata, mem_re;

    // ------------------------------------------------------------------
    // shared divider and span helpers
    // ------------------------------------------------------------------
    logic                s_accept, row_hit_in, col_hit_in;
    logic [IDX_W-1:0]    div_idx;
    logic [DIM_W-1:0]    div_dst, div_src;
    logic [DIM_W:0]      rem_sh;
    logic                div_ge;
    logic [DIM_W-1:0]    rem_step;
    logic [NUM_W-1:0]    num_step;
    logic [DIM_W-1:0]    quot;
    logic                div_done;
    logic [DIM_W-1:0]    span_w;
    logic [TOT_W-1:0]    total;
    logic                m_free, m_load, w_last, x_at_end;

    assign s_accept   = s_tvalid & s_tready;
    assign row_hit_in = rc_valid_reg & ~cfg_we & (rc_row_reg == s_tdata[COORD_W-1:0]);
    assign col_hit_in = cc_valid_reg & ~cfg_we
                        & (cc_col_reg == IDX_W'(s_tdata[2*COORD_W-1:COORD_W]));

    always_comb begin
        unique case (job_reg)
            JOB_Y0:  div_idx = IDX_W'(row_reg);
            JOB_Y1:  div_idx = IDX_W'(row_reg) + IDX_W'(1);
            JOB_X0:  div_idx = IDX_W'(col_reg);
            default: div_idx = IDX_W'(col_reg) + IDX_W'(1);
        endcase
        if (job_reg == JOB_Y0 || job_reg == JOB_Y1) begin
            div_dst = dst_h;
            div_src = src_h;
        end else begin
            div_dst = dst_w;
            div_src = src_w;
        end
    end

    // restoring division, one quotient bit per cycle
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge   = rem_sh >= {1'b0, div_src};
    assign rem_step = div_ge ? DIM_W'(rem_sh - {1'b0, div_src}) : rem_sh[DIM_W-1:0];
    assign num_step = {num_reg[NUM_W-2:0], div_ge};
    assign quot     = (num_step > NUM_W'(div_dst)) ? div_dst : DIM_W'(num_step);
    assign div_done = step_reg == STEP_W'(NUM_W - 1);

    assign span_w   = x1_reg - x0_reg;
    assign total    = TOT_W'(pend_reg) * TOT_W'(span_w);
    assign m_free   = ~m_valid_reg | m_tready;
    assign x_at_end = x_reg == (x1_reg - DIM_W'(1));
    assign w_last   = (n_reg == N_W'(MAX_REPLICAS - 1))
                      || (x_at_end && rows_reg == (pend_reg - CNT_W'(1)));

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == AW'(MAX_DIM - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = s_tuser ? ST_CLEAR : ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: state_next = ST_DIV_RUN;
            ST_DIV_RUN: begin
                if (div_done) begin
                    if (job_reg != JOB_X1) begin
                        state_next = ST_DIV_LOAD;
                    end else begin
                        state_next = row_miss_reg ? ST_SCAN_RD : ST_SETUP;
                    end
                end
            end
            ST_SCAN_RD: begin
                if (y_reg >= y1_reg || pend_reg == CNT_W'(CAP)) begin
                    state_next = ST_SETUP;
                end else begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: state_next = ST_SCAN_RD;
            ST_SETUP: begin
                if (pend_reg == '0 || span_w == '0) begin
                    state_next = ST_MARK;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: state_next = ST_EMIT_CHK;
            ST_EMIT_CHK: state_next = rd_data_reg ? ST_EMIT_RD : ST_EMIT;
            ST_EMIT: begin
                if (m_free) begin
                    if (w_last) begin
                        state_next = ST_MARK;
                    end else if (x_at_end) begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_MARK: begin
                if (!(end_reg && y_reg < y1_reg)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb begin
        s_tready  = state_reg == ST_IDLE;
        m_load    = (state_reg == ST_EMIT) && m_free;
        mem_we    = 1'b0;
        mem_wdata = 1'b0;
        mem_re    = (state_reg == ST_SCAN_RD) || (state_reg == ST_EMIT_RD);
        mem_addr  = y_reg[AW-1:0];
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_addr_reg;
            end
            ST_MARK: begin
                mem_we    = end_reg && (y_reg < y1_reg);
                mem_wdata = 1'b1;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_comb begin
        job_next      = job_reg;
        clr_addr_next = clr_addr_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        pix_next      = pix_reg;
        end_next      = end_reg;
        row_miss_next = row_miss_reg;
        col_hit_next  = col_hit_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        y0_next       = y0_reg;
        y1_next       = y1_reg;
        x0_next       = x0_reg;
        x1_next       = x1_reg;
        rc_row_next   = rc_row_reg;
        rc_valid_next = rc_valid_reg;
        cc_valid_next = cc_valid_reg;
        cc_col_next   = cc_col_reg;
        pend_next     = pend_reg;
        rows_next     = rows_reg;
        y_next        = y_reg;
        x_next        = x_reg;
        n_next        = n_reg;
        ovf_next      = ovf_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser) begin
                        clr_addr_next = '0;
                        rc_valid_next = 1'b0;
                    end else begin
                        row_next      = s_tdata[COORD_W-1:0];
                        col_next      = s_tdata[2*COORD_W-1:COORD_W];
                        pix_next      = s_tdata[2*COORD_W+PIXEL_W-1:2*COORD_W] & pix_mask;
                        end_next      = s_tlast;
                        row_miss_next = ~row_hit_in;
                        col_hit_next  = col_hit_in;
                        // row end marks rows done, so the cached count goes stale
                        rc_valid_next = row_hit_in & ~s_tlast;
                        if (col_hit_in) begin
                            x0_next = x1_reg;
                        end
                        if (!row_hit_in) begin
                            job_next    = JOB_Y0;
                            rc_row_next = s_tdata[COORD_W-1:0];
                        end else begin
                            job_next = col_hit_in ? JOB_X1 : JOB_X0;
                        end
                    end
                end
            end
            ST_DIV_LOAD: begin
                num_next  = NUM_W'(div_idx) * NUM_W'(div_dst);
                rem_next  = '0;
                step_next = '0;
            end
            ST_DIV_RUN: begin
                num_next  = num_step;
                rem_next  = rem_step;
                step_next = step_reg + STEP_W'(1);
                if (div_done) begin
                    unique case (job_reg)
                        JOB_Y0: begin
                            y0_next  = quot;
                            job_next = JOB_Y1;
                        end
                        JOB_Y1: begin
                            y1_next  = quot;
                            job_next = col_hit_reg ? JOB_X1 : JOB_X0;
                        end
                        JOB_X0: begin
                            x0_next  = quot;
                            job_next = JOB_X1;
                        end
                        default: begin
                            x1_next       = quot;
                            cc_valid_next = 1'b1;
                            cc_col_next   = IDX_W'(col_reg) + IDX_W'(1);
                        end
                    endcase
                    y_next = y0_reg;
                    // keep the cached pending count when the row is unchanged
                    if (row_miss_reg) begin
                        pend_next = '0;
                    end
                end
            end
            ST_SCAN_RD: begin
                if (y_reg >= y1_reg || pend_reg == CNT_W'(CAP)) begin
                    rc_valid_next = ~end_reg;
                end
            end
            ST_SCAN_CHK: begin
                if (!rd_data_reg) begin
                    pend_next = pend_reg + CNT_W'(1);
                end
                y_next = y_reg + DIM_W'(1);
            end
            ST_SETUP: begin
                ovf_next  = total > TOT_W'(MAX_REPLICAS);
                y_next    = y0_reg;
                n_next    = '0;
                rows_next = '0;
            end
            ST_EMIT_CHK: begin
                if (rd_data_reg) begin
                    y_next = y_reg + DIM_W'(1);
                end else begin
                    x_next = x0_reg;
                end
            end
            ST_EMIT: begin
                if (m_free) begin
                    n_next = n_reg + N_W'(1);
                    if (w_last) begin
                        y_next = y0_reg;
                    end else if (x_at_end) begin
                        y_next    = y_reg + DIM_W'(1);
                        rows_next = rows_reg + CNT_W'(1);
                    end else begin
                        x_next = x_reg + DIM_W'(1);
                    end
                end
            end
            ST_MARK: begin
                if (end_reg && y_reg < y1_reg) begin
                    y_next = y_reg + DIM_W'(1);
                end
            end
            default: ;
        endcase

        if (cfg_we) begin
            rc_valid_next = 1'b0;
            cc_valid_next = 1'b0;
        end
    end

    // output register: load a write when the slot is free, drop it once taken
    always_comb begin
        m_valid_next = m_valid_reg & ~m_tready;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_pix_next   = m_pix_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
            m_x_next     = COORD_W'(x_reg);
            m_y_next     = COORD_W'(y_reg);
            m_pix_next   = pix_reg;
            m_last_next  = w_last;
            m_ovf_next   = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            rc_valid_reg <= 1'b0;
            cc_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rc_valid_reg <= rc_valid_next;
            cc_valid_reg <= cc_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        pix_reg      <= pix_next;
        end_reg      <= end_next;
        row_miss_reg <= row_miss_next;
        col_hit_reg  <= col_hit_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        y0_reg       <= y0_next;
        y1_reg       <= y1_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        rc_row_reg   <= rc_row_next;
        cc_col_reg   <= cc_col_next;
        pend_reg     <= pend_next;
        rows_reg     <= rows_next;
        y_reg        <= y_next;
        x_reg        <= x_next;
        n_reg        <= n_next;
        ovf_reg      <= ovf_next;
        m_x_reg      <= m_x_next;
        m_y_reg      <= m_y_next;
        m_pix_reg    <= m_pix_next;
        m_last_reg   <= m_last_next;
        m_ovf_reg    <= m_ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            row_done_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= row_done_mem[mem_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pix_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_ovf_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- sv/nnrs_checker.sv -----
// ----------------------------------------------------------------------------
// nnrs_checker
// Port-level checks of the row scaler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module nnrs_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [nnrs_pkg::TDATA_W-1:0] s_tdata,
    input logic                         s_tuser,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [nnrs_pkg::TDATA_W-1:0] m_tdata,
    input logic                         m_tuser,
    input logic                         m_tlast
);
    import nnrs_pkg::*;

    localparam int PIX_LO = 2 * COORD_W;

    // the done map is swept after reset before any request is taken
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // an accepted request takes input ready low in the cycle after it
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after an accepted request");

    // writes of one pixel share the pixel value and the overflow flag
    a_same_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |->
            (m_tuser == $past(m_tuser))
            && (m_tdata[PIX_LO+PIXEL_W-1:PIX_LO] == $past(m_tdata[PIX_LO+PIXEL_W-1:PIX_LO])))
        else $error("pixel or overflow changed within one pixel's writes");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled write changed");

endmodule

bind nearest_neighbor_row_scaler nnrs_checker u_nnrs_checker (.*);

// ----- tb/nearest_neighbor_row_scaler_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_neighbor_row_scaler_tb
// Self-checking bench for the row scaler. Directed tests cover reset values,
// byte masking, done-row skipping, span clipping, the replica cap and
// dimension clamping; a random part streams whole and broken frames under
// changing scale settings. A predictor kept in the bench expands every
// accepted request into its destination writes, and a monitor compares each
// write leaving the block with the oldest expected one. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module nearest_neighbor_row_scaler_tb;
    import nnrs_pkg::*;

    localparam int DIM_LIMIT     = DEF_MAX_DIM;
    localparam int REPLICA_LIMIT = DEF_MAX_REPLICAS;
    localparam longint CYCLE_LIMIT = 10_000_000;
    localparam logic [2:0] REG_UNUSED = 3'd5;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIXEL_W-1:0] pixel;
        logic               last;
        logic               overflow;
    } dst_write_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata = '0;     // src_row [11:0], src_col [23:12], pixel_in [55:24]
    logic                s_tuser = 1'b0;   // mode
    logic                s_tlast = 1'b0;   // row_end
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;          // dst_x [11:0], dst_y [23:12], pixel_out [55:24]
    logic                m_tuser;          // overflow
    logic                m_tlast;          // last
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // predictor state
    logic [DIMREG_W-1:0] cfg_dim [4];
    logic [BPPREG_W-1:0] cfg_bpp;
    bit                  row_done [DIM_LIMIT];
    dst_write_t          expected_writes [$];

    bit          quiet = 1'b0;
    int unsigned ready_hold = 0;
    longint      cycle_count = 0;
    int          mismatches = 0;
    int          pixels_sent = 0;
    int          scans_sent = 0;
    int          settings_used = 0;
    int          writes_checked = 0;
    int          overflow_writes = 0;

    nearest_neighbor_row_scaler DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes outstanding",
                     cycle_count, expected_writes.size());
            $display("** nearest_neighbor_row_scaler: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int dim_eff(input logic [DIMREG_W-1:0] v);
        if (v == 0) return 1;
        if (v > DIM_LIMIT) return DIM_LIMIT;
        return int'(v);
    endfunction

    function automatic longint unsigned span_bound(input longint unsigned i,
                                                   input longint unsigned dst,
                                                   input longint unsigned src);
        longint unsigned v;
        v = (i * dst) / src;
        return (v > dst) ? dst : v;
    endfunction

    task automatic expand_request(input logic is_scan, input logic [COORD_W-1:0] row,
                                  input logic [COORD_W-1:0] col,
                                  input logic [PIXEL_W-1:0] pix, input logic rend);
        longint unsigned sw, sh, dw, dh, y0, y1, x0, x1, pending, total, emit_cnt;
        longint unsigned n;
        int          bpp;
        logic [PIXEL_W-1:0] kept;
        dst_write_t  w;
        if (is_scan) begin
            foreach (row_done[i]) row_done[i] = 1'b0;
            return;
        end
        sw = dim_eff(cfg_dim[REG_SRC_WIDTH]);
        sh = dim_eff(cfg_dim[REG_SRC_HEIGHT]);
        dw = dim_eff(cfg_dim[REG_DST_WIDTH]);
        dh = dim_eff(cfg_dim[REG_DST_HEIGHT]);
        bpp = (cfg_bpp == 0) ? 1 : int'(cfg_bpp);
        kept = (bpp < 4) ? (pix & (32'hFFFF_FFFF >> (32 - 8 * bpp))) : pix;
        y0 = span_bound(row, dh, sh);
        y1 = span_bound(longint'(row) + 1, dh, sh);
        x0 = span_bound(col, dw, sw);
        x1 = span_bound(longint'(col) + 1, dw, sw);
        pending = 0;
        for (longint unsigned y = y0; y < y1; y++)
            if (!row_done[y]) pending++;
        total = pending * (x1 - x0);
        emit_cnt = (total > REPLICA_LIMIT) ? REPLICA_LIMIT : total;
        n = 0;
        for (longint unsigned y = y0; y < y1 && n < emit_cnt; y++) begin
            if (row_done[y]) continue;
            for (longint unsigned x = x0; x < x1 && n < emit_cnt; x++) begin
                w.x = x[COORD_W-1:0];
                w.y = y[COORD_W-1:0];
                w.pixel = kept;
                w.last = (n + 1 == emit_cnt);
                w.overflow = (total > REPLICA_LIMIT);
                expected_writes.push_back(w);
                n++;
            end
        end
        if (rend)
            for (longint unsigned y = y0; y < y1; y++) row_done[y] = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // stream drivers and monitor
    // ------------------------------------------------------------------------
    function automatic int stall_length();
        if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold = ready_hold - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            ready_hold = stall_length() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        dst_write_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[11:0];
            got.y = m_tdata[23:12];
            got.pixel = m_tdata[55:24];
            got.last = m_tlast;
            got.overflow = m_tuser;
            writes_checked++;
            if (got.overflow) overflow_writes++;
            if (expected_writes.size() == 0) begin
                if (mismatches < 10)
                    $display("cycle %0d: unexpected write x=%0d y=%0d pixel=%h last=%b ovf=%b",
                             cycle_count, got.x, got.y, got.pixel, got.last, got.overflow);
                mismatches++;
            end else begin
                want = expected_writes.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.pixel !== want.pixel ||
                    got.last !== want.last || got.overflow !== want.overflow) begin
                    if (mismatches < 10) begin
                        $display("cycle %0d: write mismatch", cycle_count);
                        $display("  expected x=%0d y=%0d pixel=%h last=%b ovf=%b",
                                 want.x, want.y, want.pixel, want.last, want.overflow);
                        $display("  actual   x=%0d y=%0d pixel=%h last=%b ovf=%b",
                                 got.x, got.y, got.pixel, got.last, got.overflow);
                    end
                    mismatches++;
                end
            end
        end
    end

    task automatic send_request(input logic is_scan, input logic [COORD_W-1:0] row,
                                input logic [COORD_W-1:0] col,
                                input logic [PIXEL_W-1:0] pix, input logic rend);
        int gap;
        gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : stall_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {pix, col, row};
        s_tuser <= is_scan;
        s_tlast <= rend;
        do @(posedge aclk); while (!s_tready);
        expand_request(is_scan, row, col, pix, rend);
        if (is_scan) scans_sent++;
        else pixels_sent++;
    endtask

    task automatic wait_for_writes();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_writes.size() != 0);
    endtask

    function automatic int settle_cycles();
        int rows;
        rows = dim_eff(cfg_dim[REG_DST_HEIGHT]) / dim_eff(cfg_dim[REG_SRC_HEIGHT]) + 2;
        return DIM_LIMIT + 6 * rows + 4 * REPLICA_LIMIT + 200;
    endfunction

    // drain results, then let any result-free work finish
    task automatic quiesce();
        wait_for_writes();
        repeat (settle_cycles()) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] idx, input logic [APB_DW-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT:
                cfg_dim[idx] = val[DIMREG_W-1:0];
            REG_BPP: cfg_bpp = val[BPPREG_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apb_check(input logic [2:0] idx);
        logic [APB_DW-1:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        want = (idx == REG_BPP) ? APB_DW'(cfg_bpp) : APB_DW'(cfg_dim[idx]);
        if (prdata !== want) begin
            if (mismatches < 10)
                $display("register %0d reads %h, expected %h", idx, prdata, want);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [APB_DW-1:0] sw, input logic [APB_DW-1:0] sh,
                              input logic [APB_DW-1:0] dw, input logic [APB_DW-1:0] dh,
                              input logic [APB_DW-1:0] bpp);
        quiesce();
        apb_write(REG_SRC_WIDTH, sw);
        apb_write(REG_SRC_HEIGHT, sh);
        apb_write(REG_DST_WIDTH, dw);
        apb_write(REG_DST_HEIGHT, dh);
        apb_write(REG_BPP, bpp);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_request(1'b0, 12'd0, 12'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(1'b0, 12'd0, 12'd0, 32'h0000_0000, 1'b1);
    endtask

    task automatic test_register_access();
        quiesce();
        apb_write(REG_SRC_WIDTH, 32'hFFFF_FFFF);
        apb_write(REG_SRC_HEIGHT, 32'hFFFF_E005);
        apb_write(REG_DST_WIDTH, 32'd4096);
        apb_write(REG_DST_HEIGHT, 32'd0);
        apb_write(REG_BPP, 32'hFFFF_FFFA);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        for (int i = 0; i < 5; i++) apb_check(3'(i));
        settings_used++;
    endtask

    task automatic test_pixel_masking();
        set_config(4, 4, 8, 8, 1);
        send_request(1'b0, 12'd0, 12'd0, 32'hA5C3_96E1, 1'b0);
        quiesce();
        apb_write(REG_BPP, 3);
        send_request(1'b0, 12'd1, 12'd1, 32'hFFFF_FFFF, 1'b0);
        quiesce();
        apb_write(REG_BPP, 0);
        send_request(1'b0, 12'd2, 12'd2, 32'h1234_5678, 1'b0);
        quiesce();
        apb_write(REG_BPP, 7);
        send_request(1'b0, 12'd3, 12'd3, 32'hDEAD_BEEF, 1'b0);
        quiesce();
        apb_write(REG_BPP, 2);
        send_request(1'b0, 12'd3, 12'd0, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_done_rows_and_new_scan();
        set_config(4, 4, 8, 8, 4);
        send_request(1'b0, 12'd0, 12'd3, 32'h0101_0101, 1'b1);
        send_request(1'b0, 12'd0, 12'd2, 32'h0202_0202, 1'b0);   // rows already done
        send_request(1'b0, 12'd1, 12'd0, 32'h0303_0303, 1'b0);
        send_request(1'b1, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(1'b0, 12'd0, 12'd2, 32'h0404_0404, 1'b0);
    endtask

    task automatic test_span_clipping();
        send_request(1'b0, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(1'b0, 12'd4, 12'd0, 32'h5555_5555, 1'b1);
        send_request(1'b0, 12'd2, 12'd4, 32'hAAAA_AAAA, 1'b1);
        send_request(1'b0, 12'd2, 12'd1, 32'h0F0F_0F0F, 1'b0);   // rows already done
    endtask

    task automatic test_replica_cap();
        set_config(1, 1, 8, 8, 4);
        send_request(1'b0, 12'd0, 12'd0, 32'h8888_8888, 1'b0);   // exactly at the cap
        set_config(1, 1, 5, 13, 4);
        send_request(1'b0, 12'd0, 12'd0, 32'h9999_9999, 1'b0);   // one past the cap
        set_config(1, 1, 4096, 4096, 4);
        send_request(1'b0, 12'd0, 12'd0, 32'h7777_7777, 1'b1);
        send_request(1'b0, 12'd0, 12'd0, 32'h6666_6666, 1'b0);
    endtask

    task automatic test_dim_clamping();
        set_config(0, 2, 8191, 2, 4);
        send_request(1'b0, 12'd0, 12'd0, 32'h1357_9BDF, 1'b0);
        send_request(1'b0, 12'd1, 12'd0, 32'h2468_ACE0, 1'b1);
        set_config(5000, 5000, 0, 0, 4);
        send_request(1'b0, 12'hFFF, 12'hFFF, 32'hC0FF_EE00, 1'b1);
        send_request(1'b0, 12'd0, 12'd0, 32'h0BAD_F00D, 1'b1);
    endtask

    task automatic send_noise();
        int sw, sh;
        sw = dim_eff(cfg_dim[REG_SRC_WIDTH]);
        sh = dim_eff(cfg_dim[REG_SRC_HEIGHT]);
        case ($urandom_range(0, 3))
            0: send_request(1'b1, 12'($urandom), 12'($urandom), $urandom, 1'($urandom));
            1: send_request(1'b0, 12'($urandom), 12'($urandom), $urandom, 1'($urandom));
            2: send_request(1'b0, 12'(sh + $urandom_range(0, 1)), 12'(sw + $urandom_range(0, 1)),
                            $urandom, 1'($urandom));
            default: send_request(1'b0, 12'($urandom_range(0, sh - 1)),
                                  12'($urandom_range(0, sw - 1)), $urandom, 1'($urandom));
        endcase
    endtask

    task automatic run_frame();
        int sw, sh;
        bit broken;
        logic [COORD_W-1:0] row;
        logic rend;
        sw = dim_eff(cfg_dim[REG_SRC_WIDTH]);
        sh = dim_eff(cfg_dim[REG_SRC_HEIGHT]);
        broken = ($urandom_range(0, 3) == 0);
        quiet = ($urandom_range(0, 4) == 0);
        if (!broken || $urandom_range(0, 1) == 0)
            send_request(1'b1, 12'($urandom), 12'($urandom), $urandom, 1'($urandom));
        for (int r = 0; r < sh; r++) begin
            row = (broken && r > 0 && $urandom_range(0, 2) == 0) ? 12'(r - 1) : 12'(r);
            for (int c = 0; c < sw; c++) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                rend = broken ? 1'($urandom) : (c == sw - 1);
                send_request(1'b0, row, 12'(c), $urandom, rend);
            end
            if ($urandom_range(0, 11) == 0) wait_for_writes();
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_frames();
        int target;
        target = pixels_sent + 450;
        while (pixels_sent < target) begin
            set_config($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(1, 16),
                       $urandom_range(1, 16), $urandom_range(0, 7));
            repeat ($urandom_range(2, 4))
                if (pixels_sent < target) run_frame();
        end
    endtask

    initial begin
        cfg_dim[REG_SRC_WIDTH] = DIM_RESET;
        cfg_dim[REG_SRC_HEIGHT] = DIM_RESET;
        cfg_dim[REG_DST_WIDTH] = DIM_RESET;
        cfg_dim[REG_DST_HEIGHT] = DIM_RESET;
        cfg_bpp = BPP_RESET;
        foreach (row_done[i]) row_done[i] = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_register_access();
        test_pixel_masking();
        test_done_rows_and_new_scan();
        test_span_clipping();
        test_replica_cap();
        test_dim_clamping();
        test_random_frames();

        quiesce();
        $display("Sent %0d pixel requests and %0d new scans over %0d scale settings.",
                 pixels_sent, scans_sent, settings_used);
        $display("Checked %0d destination writes, %0d of them flagged overflow; %0d mismatches.",
                 writes_checked, overflow_writes, mismatches);
        if (mismatches == 0 && expected_writes.size() == 0) begin
            $display("** nearest_neighbor_row_scaler: PASSED **");
        end else begin
            $display("** nearest_neighbor_row_scaler: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/nnrs_pkg.sv
sv/nearest_neighbor_row_scaler.sv
sv/nnrs_checker.sv
tb/nearest_neighbor_row_scaler_tb.sv
